// ===== hdl/blst_pkg.sv =====
// ----------------------------------------------------------------------------
// blst_pkg
// Shared types, constants and a helper function for the bounded list core.
// ----------------------------------------------------------------------------
package blst_pkg;

  localparam int CAPACITY    = 16;
  localparam int ENTRY_WIDTH = 32;

  // Field widths of the transactions.
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_SHUFFLE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_RM_READ,
    S_RM_TAKE,
    S_RM_MOVE,
    S_SH_RAND,
    S_SH_MOD,
    S_SH_RDJ,
    S_SH_WRI,
    S_SH_WRJ,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] entry_in;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] entry_out;
    logic              entry_valid;
    logic              dropped;
    logic [4:0]        entry_count;
    logic              list_full;
  } out_t;

  // One step of the Galois LFSR.
  function automatic logic [31:0] lfsr_step(input logic [31:0] v);
    logic [31:0] s;
    s = {1'b0, v[31:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

// ===== hdl/blst_ram.sv =====
// ----------------------------------------------------------------------------
// blst_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blst_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/blst_mod.sv =====
// ----------------------------------------------------------------------------
// blst_mod
// Iterative remainder unit: a 32-bit word modulo a small divisor, four
// dividend bits per cycle.
// ----------------------------------------------------------------------------
module blst_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                dividend,
  input  logic [blst_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [blst_pkg::IDX_W-1:0] rem
);
  import blst_pkg::*;

  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = 32 / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);
  localparam int TW            = IDX_W + 1;

  logic [31:0]       shreg;
  logic [TW-1:0]     div_q;
  logic [IDX_W-1:0]  rem_next;
  logic [STEP_W-1:0] step;
  logic              busy;

  // Restoring reduction; the partial remainder stays below the divisor, so
  // one compare and subtract per bit suffices.
  always_comb begin
    logic [TW-1:0] t;
    logic [IDX_W-1:0] r;
    r = rem;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      t = {r, shreg[31-k]};
      if (t >= div_q) begin
        t = t - div_q;
      end
      r = t[IDX_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div_q <= TW'(divisor);
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
      rem   <= rem_next;
    end
  end

endmodule

// ===== hdl/bounded_list_append_remove_shuffle_core.sv =====
// ----------------------------------------------------------------------------
// bounded_list_append_remove_shuffle_core
// Bounded ordered list with append, remove-at-position and LFSR shuffle.
// ----------------------------------------------------------------------------
// The list of up to CAPACITY entry words lives in a single simple dual-port
// memory with a registered read; a state machine reads, modifies and
// writes it back, one item at a time. An input transaction is taken only
// while the core is idle, and the finished result is held in an output
// register, so the next transaction may be taken while a result still waits
// downstream. A remove at position p makes one memory move per later entry.
// A shuffle of n entries makes n - 1 swaps: for each, the remainder unit
// picks the partner slot (four bits of the random word per cycle), and the
// swap reads the partner and writes both slots through the single read and
// single write port. The LFSR state register is written through the cfg
// channel, which is ready only while the core is idle; a zero seed is loaded
// as one.
// ----------------------------------------------------------------------------
module bounded_list_append_remove_shuffle_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  blst_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output blst_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import blst_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam int CW = CNT_W + POS_W;

  state_t state, state_next;

  // Item held for the duration of the work.
  logic [ENTRY_WIDTH-1:0] entry_q;

  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       j_q;
  logic [ENTRY_WIDTH-1:0] tmp;
  logic [ENTRY_WIDTH-1:0] removed;
  logic                   rm_ok;
  logic                   drop_q;
  logic [31:0]            lfsr;

  // Memory port and remainder unit controls.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;
  logic                   mod_start;
  logic                   mod_done;
  logic [IDX_W-1:0]       mod_rem;

  logic in_accept;
  logic cfg_accept;
  logic out_load;
  logic pos_ok;
  logic idx_p1_lt;
  logic idx_p2_lt;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = (state == S_IDLE);
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_load   = (state == S_FINISH) && (!out_valid || !out_stall);

  // A remove position is valid when it lies in 1..count.
  assign pos_ok = (in_data.position != '0) && (CW'(in_data.position) <= CW'(count));

  // Whether an entry lies above the slot being filled during the shift.
  assign idx_p1_lt = (CW'(idx) + CW'(1)) < CW'(count);
  assign idx_p2_lt = (CW'(idx) + CW'(2)) < CW'(count);

  blst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  blst_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (lfsr_step(lfsr)),
    .divisor  (CNT_W'(idx) + CNT_W'(1)),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.op)
            OP_APPEND:  state_next = (count < CAP_CNT) ? S_APPEND : S_FINISH;
            OP_REMOVE:  state_next = pos_ok ? S_RM_READ : S_FINISH;
            OP_SHUFFLE: state_next = (count >= CNT_W'(2)) ? S_SH_RAND : S_FINISH;
            OP_NONE:    state_next = S_FINISH;
          endcase
        end
      end
      S_APPEND:  state_next = S_FINISH;
      S_RM_READ: state_next = S_RM_TAKE;
      S_RM_TAKE: state_next = idx_p1_lt ? S_RM_MOVE : S_FINISH;
      S_RM_MOVE: state_next = idx_p2_lt ? S_RM_MOVE : S_FINISH;
      S_SH_RAND: state_next = S_SH_MOD;
      S_SH_MOD:  state_next = mod_done ? S_SH_RDJ : S_SH_MOD;
      S_SH_RDJ:  state_next = S_SH_WRI;
      S_SH_WRI:  state_next = S_SH_WRJ;
      S_SH_WRJ:  state_next = (idx == IDX_W'(1)) ? S_FINISH : S_SH_RAND;
      S_FINISH:  state_next = out_load ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory and remainder unit controls for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = idx;
    mod_start = 1'b0;
    unique case (state)
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = entry_q;
      end
      S_RM_TAKE: begin
        ram_raddr = idx + IDX_W'(1);
      end
      S_RM_MOVE: begin
        // Entry idx+1 arrived this cycle; fetch idx+2 for the next move.
        ram_we    = 1'b1;
        ram_raddr = idx + IDX_W'(2);
      end
      S_SH_RAND: begin
        mod_start = 1'b1;
      end
      S_SH_RDJ: begin
        ram_raddr = j_q;
      end
      S_SH_WRI: begin
        ram_we = 1'b1;
      end
      S_SH_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = tmp;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lfsr      <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_accept) begin
        lfsr <= (cfg_data == '0) ? 32'd1 : cfg_data;
      end else if (state == S_SH_RAND) begin
        lfsr <= lfsr_step(lfsr);
      end
      if (state == S_APPEND) begin
        count <= count + CNT_W'(1);
      end else if ((state == S_RM_TAKE && !idx_p1_lt) ||
                   (state == S_RM_MOVE && !idx_p2_lt)) begin
        count <= count - CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      entry_q <= in_data.entry_in[ENTRY_WIDTH-1:0];
      removed <= '0;
      rm_ok   <= (in_data.op == OP_REMOVE) && pos_ok;
      drop_q  <= (in_data.op == OP_APPEND) && (count == CAP_CNT);
      if (in_data.op == OP_REMOVE) begin
        idx <= IDX_W'(in_data.position - POS_W'(1));
      end else begin
        idx <= IDX_W'(count - CNT_W'(1));
      end
    end else begin
      unique case (state)
        S_RM_TAKE: removed <= ram_rdata;
        S_RM_MOVE: idx     <= idx + IDX_W'(1);
        S_SH_MOD:  j_q     <= mod_rem;
        S_SH_RDJ:  tmp     <= ram_rdata;
        S_SH_WRJ:  idx     <= idx - IDX_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.entry_out   <= WORD_W'(removed);
      out_data.entry_valid <= rm_ok;
      out_data.dropped     <= drop_q;
      out_data.entry_count <= 5'(count);
      out_data.list_full   <= (count == CAP_CNT);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count exceeds capacity");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> (count < CAP_CNT))
    else $error("append write with a full list");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RM_TAKE || state == S_RM_MOVE) |-> (CW'(idx) < CW'(count)))
    else $error("remove shift beyond the held entries");

  a_partner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_MOD && mod_done) |-> (mod_rem <= idx))
    else $error("shuffle partner slot above the current slot");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && out_stall) |=> (state == S_FINISH))
    else $error("pending result overwritten");

endmodule
